FILE: hw/rtl/qaa_pkg.sv
// Shared types, constants and tables for the quaternion to axis-angle block.
`timescale 1ns / 1ps
package qaa_pkg;

   localparam int unsigned CordicSteps = 16;
   localparam int unsigned DivBits     = 31;
   localparam int unsigned SqrtSteps   = 16;

   typedef struct packed {
      logic [15:0] w_raw;
      logic [15:0] i_raw;
      logic [15:0] j_raw;
      logic [15:0] k_raw;
   } req_type;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic [15:0]        angle_deg;
      logic               degenerate;
      logic               axis_clipped;
   } rsp_type;

   localparam logic signed [26:0] Deg90Units  = 27'sd5898240;
   localparam logic signed [26:0] Deg180Units = 27'sd11796480;

   function automatic logic [21:0] atan_deg(input logic [3:0] idx);
      logic [21:0] r;
      case (idx)
         4'd0:  r = 22'd2949120;
         4'd1:  r = 22'd1740967;
         4'd2:  r = 22'd919879;
         4'd3:  r = 22'd466945;
         4'd4:  r = 22'd234379;
         4'd5:  r = 22'd117304;
         4'd6:  r = 22'd58666;
         4'd7:  r = 22'd29335;
         4'd8:  r = 22'd14668;
         4'd9:  r = 22'd7334;
         4'd10: r = 22'd3667;
         4'd11: r = 22'd1833;
         4'd12: r = 22'd917;
         4'd13: r = 22'd458;
         4'd14: r = 22'd229;
         default: r = 22'd115;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/qaa_sqrt_stage.sv
// One restoring square-root step: two radicand bits per stage.
`timescale 1ns / 1ps
module qaa_sqrt_stage (
   input  logic        clock,
   input  logic        adv,
   input  logic [30:0] rem_in,
   input  logic [15:0] root_in,
   input  logic [31:0] rad_in,
   output logic [30:0] rem_ff,
   output logic [15:0] root_ff,
   output logic [31:0] rad_ff
);
   logic [32:0] trial;
   logic [32:0] sh;

   always_comb begin
      sh    = {rem_in, rad_in[31:30]};
      trial = sh - {15'd0, root_in, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (!trial[32]) begin
            rem_ff  <= trial[30:0];
            root_ff <= {root_in[14:0], 1'b1};
         end else begin
            rem_ff  <= sh[30:0];
            root_ff <= {root_in[14:0], 1'b0};
         end
         rad_ff <= {rad_in[29:0], 2'b00};
      end
   end
endmodule

FILE: hw/rtl/qaa_cordic_stage.sv
// One vectoring CORDIC rotation with its angle accumulation.
`timescale 1ns / 1ps
module qaa_cordic_stage #(
   parameter int unsigned Shift = 0
) (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [26:0] x_in,
   input  logic signed [26:0] y_in,
   input  logic signed [26:0] acc_in,
   output logic signed [26:0] x_ff,
   output logic signed [26:0] y_ff,
   output logic signed [26:0] acc_ff
);
   import qaa_pkg::*;

   logic signed [26:0] xs, ys, step;

   always_comb begin
      xs   = x_in >>> Shift;
      ys   = y_in >>> Shift;
      step = $signed({5'd0, atan_deg(4'(Shift))});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (y_in > 0) begin
            x_ff   <= x_in + ys;
            y_ff   <= y_in - xs;
            acc_ff <= acc_in + step;
         end else begin
            x_ff   <= x_in - ys;
            y_ff   <= y_in + xs;
            acc_ff <= acc_in - step;
         end
      end
   end
endmodule

FILE: hw/rtl/qaa_div_stage.sv
// One restoring division step for the three axis quotients.
`timescale 1ns / 1ps
module qaa_div_stage (
   input  logic        clock,
   input  logic        adv,
   input  logic [15:0] den,
   input  logic [16:0] rem_in [3],
   input  logic [30:0] num_in [3],
   output logic [16:0] rem_ff [3],
   output logic [30:0] num_ff [3]
);
   logic [17:0] sh [3];
   logic [17:0] diff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sh[k]   = {rem_in[k], num_in[k][30]};
         diff[k] = sh[k] - {2'd0, den};
      end
   end

   // remainder stays below den, so 17 bits hold it
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            if (!diff[k][17]) begin
               rem_ff[k] <= diff[k][16:0];
               num_ff[k] <= {num_in[k][29:0], 1'b1};
            end else begin
               rem_ff[k] <= sh[k][16:0];
               num_ff[k] <= {num_in[k][29:0], 1'b0};
            end
         end
      end
   end
endmodule

FILE: hw/rtl/quaternion_to_axis_angle_top.sv
// Top level of the quaternion to axis-angle converter pipeline.
//
// Input channel req_*: one quaternion (four offset-binary words) per
// transfer. Output channel rsp_*: rotation axis (Q2.14), angle in
// degrees times 256, degenerate and clipping flags.
// Pipeline: 50 register stages (one square step, 16 root stages, a CORDIC
// prep stage, 31 quotient stages and a final packing stage; the CORDIC runs
// beside the divider).
// Throughput: one item per cycle unless rsp_ready stalls the pipeline; every stage holds one item.
// The pipeline advances whenever its output slot is empty or taken, so a
// stall on rsp_ready freezes every stage and nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module quaternion_to_axis_angle_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qaa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qaa_pkg::rsp_type rsp_data
);
   import qaa_pkg::*;

   localparam int unsigned Depth = 1 + SqrtSteps + 1 + DivBits + 1;

   logic adv;
   logic [Depth-1:0] vld_ff;

   assign adv       = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   // stage 0: signed components and radicand
   logic signed [15:0] q_ff [4];
   logic [31:0] d_ff;
   logic signed [15:0] q_in [4];
   always_comb begin
      q_in[0] = $signed(req_data.w_raw ^ 16'h8000);
      q_in[1] = $signed(req_data.i_raw ^ 16'h8000);
      q_in[2] = $signed(req_data.j_raw ^ 16'h8000);
      q_in[3] = $signed(req_data.k_raw ^ 16'h8000);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff <= q_in;
         d_ff <= 32'h4000_0000 - 32'(q_in[0] * q_in[0]);
      end
   end

   // square root stages, with component delay line
   logic [30:0] srem [SqrtSteps+1];
   logic [15:0] sroot [SqrtSteps+1];
   logic [31:0] srad [SqrtSteps+1];
   logic signed [15:0] sq [SqrtSteps+1][4];
   assign srem[0]  = '0;
   assign sroot[0] = '0;
   assign srad[0]  = d_ff;
   assign sq[0]    = q_ff;

   for (genvar s = 0; s < SqrtSteps; s++) begin : g_sqrt
      qaa_sqrt_stage u_stage (
         .clock, .adv,
         .rem_in(srem[s]), .root_in(sroot[s]), .rad_in(srad[s]),
         .rem_ff(srem[s+1]), .root_ff(sroot[s+1]), .rad_ff(srad[s+1])
      );
      logic signed [15:0] qd_ff [4];
      always_ff @(posedge clock) begin
         if (adv) qd_ff <= sq[s];
      end
      assign sq[s+1] = qd_ff;
   end

   // root of 2^30 is 32768, which still fits the 16-bit root in bit 15
   logic [16:0] scale;
   assign scale = {1'b0, sroot[SqrtSteps]};

   // prep stage: CORDIC start point, division operands
   logic [16:0] sc_ff;
   logic signed [26:0] cx_ff, cy_ff, cacc_ff;
   logic signed [15:0] pq_ff [4];
   logic signed [26:0] x0, y0;
   always_comb begin
      x0 = 27'(sq[SqrtSteps][0]) <<< 8;
      y0 = $signed({2'b0, scale, 8'd0});
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sc_ff <= scale;
         pq_ff <= sq[SqrtSteps];
         if (x0 < 0) begin
            cx_ff   <= y0;
            cy_ff   <= -x0;
            cacc_ff <= Deg90Units;
         end else begin
            cx_ff   <= x0;
            cy_ff   <= y0;
            cacc_ff <= '0;
         end
      end
   end

   // sqrt of a radicand of at most 2^30 is at most 32768, so 16 root stages cover it
   // division: |q| * 16384 over scale, 31 quotient bits
   logic [16:0] drem [DivBits+1][3];
   logic [30:0] dnum [DivBits+1][3];
   logic [15:0] den  [DivBits+1];
   logic [16:0] dsc  [DivBits+1];
   logic signed [15:0] dq [DivBits+1][4];
   logic signed [26:0] cx [DivBits+1];
   logic signed [26:0] cy [DivBits+1];
   logic signed [26:0] ca [DivBits+1];

   for (genvar k = 0; k < 3; k++) begin : g_num
      assign drem[0][k] = '0;
      assign dnum[0][k] = {1'b0,
                           pq_ff[k+1][15] ? 16'(-pq_ff[k+1]) : 16'(pq_ff[k+1]),
                           14'd0};
   end
   // a divisor of 32768 needs bit 15 only; 16 bits suffice
   assign den[0] = sc_ff[15:0] | {sc_ff[16], 15'd0};
   assign dsc[0] = sc_ff;
   assign dq[0]  = pq_ff;
   assign cx[0]  = cx_ff;
   assign cy[0]  = cy_ff;
   assign ca[0]  = cacc_ff;

   for (genvar s = 0; s < DivBits; s++) begin : g_div
      qaa_div_stage u_div (
         .clock, .adv, .den(den[s]),
         .rem_in(drem[s]), .num_in(dnum[s]),
         .rem_ff(drem[s+1]), .num_ff(dnum[s+1])
      );
      logic [16:0] sc_d_ff;
      logic signed [15:0] q_d_ff [4];
      always_ff @(posedge clock) begin
         if (adv) begin
            sc_d_ff <= dsc[s];
            q_d_ff  <= dq[s];
         end
      end
      assign dsc[s+1] = sc_d_ff;
      assign den[s+1] = sc_d_ff[15:0] | {sc_d_ff[16], 15'd0};
      assign dq[s+1]  = q_d_ff;
      if (s < CordicSteps) begin : g_cor
         qaa_cordic_stage #(.Shift(s)) u_cor (
            .clock, .adv,
            .x_in(cx[s]), .y_in(cy[s]), .acc_in(ca[s]),
            .x_ff(cx[s+1]), .y_ff(cy[s+1]), .acc_ff(ca[s+1])
         );
      end else begin : g_hold
         logic signed [26:0] a_d_ff;
         always_ff @(posedge clock) begin
            if (adv) a_d_ff <= ca[s];
         end
         assign ca[s+1] = a_d_ff;
         assign cx[s+1] = cx[s];
         assign cy[s+1] = cy[s];
      end
   end

   // output stage: sign, saturation, degenerate zeroing, angle clamping and rounding
   rsp_type out_in, out_ff;
   logic [15:0] ax_v [3];
   logic [2:0] clip;
   logic signed [26:0] acc_c;
   logic [26:0] acc_r;
   logic degen;
   always_comb begin
      degen = (dsc[DivBits] == 17'd0);
      for (int k = 0; k < 3; k++) begin
         clip[k] = 1'b0;
         if (dq[DivBits][k+1][15]) begin
            if (dnum[DivBits][k] > 31'd32768) begin
               clip[k] = 1'b1;
               ax_v[k] = 16'h8000;
            end else begin
               ax_v[k] = 16'(-dnum[DivBits][k]);
            end
         end else if (dnum[DivBits][k] > 31'd32767) begin
            clip[k] = 1'b1;
            ax_v[k] = 16'h7fff;
         end else begin
            ax_v[k] = dnum[DivBits][k][15:0];
         end
         if (degen) begin
            clip[k] = 1'b0;
            ax_v[k] = '0;
         end
      end
      acc_c = ca[DivBits];
      if (acc_c < 0) acc_c = '0;
      if (acc_c > Deg180Units) acc_c = Deg180Units;
      acc_r = 27'(acc_c) + 27'd128;
      out_in.axis_x       = $signed(ax_v[0]);
      out_in.axis_y       = $signed(ax_v[1]);
      out_in.axis_z       = $signed(ax_v[2]);
      out_in.angle_deg    = acc_r[23:8];
      out_in.degenerate   = degen;
      out_in.axis_clipped = |clip;
   end
   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end
   assign rsp_data = out_ff;
endmodule
